[src/mdag_pkg.sv]
// Shared types, widths and constants of the mic DC blocker / AGC / noise gate.
// Used by the interfaces, the register block, the divider and the top level; no dependencies.
package mdag_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_REG_W    = 24;
    localparam int LEVEL_W       = 15;
    localparam int ENV_W         = 24;
    localparam int GAIN_W        = 16;
    localparam int HP_MAG_W      = 26;
    localparam int GATE_F_W      = 17;

    localparam int COEF_BITS_DEF = 24;
    localparam int GAIN_MAX_DEF  = 32768;
    localparam int GAIN_MIN_DEF  = 1024;

    localparam int GAIN_ONE      = 4096;
    localparam int GATE_FLOOR    = 16463;
    localparam int GATE_ONE      = 65536;
    localparam int GATE_SPAN     = GATE_ONE - GATE_FLOOR;
    localparam int ENV_QUIET     = 256;

    localparam logic [ENV_W-1:0] Y_POS_MAX = 24'h7FFFFF;
    localparam logic [ENV_W-1:0] Y_NEG_MAG = 24'h800000;

    localparam int DIV_DVD_W     = 40;
    localparam int DIV_DVS_W     = 24;
    localparam int DIV_QUO_W     = 17;

    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_HIGHPASS   = 3'd0,
        REG_ATTACK     = 3'd1,
        REG_RELEASE    = 3'd2,
        REG_GATE_SMOOTH = 3'd3,
        REG_GAIN_SLEW  = 3'd4,
        REG_TARGET     = 3'd5,
        REG_GATE_THR   = 3'd6,
        REG_AGC_EN     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_REG_W-1:0] highpass_coef;
        logic [COEF_REG_W-1:0] attack_coef;
        logic [COEF_REG_W-1:0] release_coef;
        logic [COEF_REG_W-1:0] gate_smooth_coef;
        logic [COEF_REG_W-1:0] gain_slew_coef;
        logic [LEVEL_W-1:0]    target_level;
        logic [LEVEL_W-1:0]    gate_threshold;
        logic                  agc_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        highpass_coef:    24'd16131293,
        attack_coef:      24'd16568838,
        release_coef:     24'd16773721,
        gate_smooth_coef: 24'd16756262,
        gain_slew_coef:   24'd16724870,
        target_level:     15'd4125,
        gate_threshold:   15'd184,
        agc_enable:       1'b1
    };

    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

[src/mdag_if.sv]
// Valid/ready item channels for the sample input and the sample output.
// Depends on mdag_pkg for the sample width.
interface mdag_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mdag_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

interface mdag_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mdag_pkg::SAMPLE_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

[src/mdag_mul.sv]
// Shared unsigned multiplier with a registered product.
// Self-contained; widths come from the instantiating module.
module mdag_mul #(
    parameter int A_W = 24,
    parameter int B_W = 26
) (
    input  logic               clk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;
    logic [A_W+B_W-1:0] p_next;

    always_comb
    begin
        p_next = p_reg;
        if (en)
        begin
            p_next = {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[src/mdag_div.sv]
// Shared restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on mdag_pkg for operand widths and the status struct.
module mdag_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mdag_pkg::DIV_DVD_W-1:0]   dividend,
    input  logic [mdag_pkg::DIV_DVS_W-1:0]   divisor,
    output logic [mdag_pkg::DIV_QUO_W-1:0]   quotient,
    output mdag_pkg::div_status_t            status
);

    localparam int DVD_W = mdag_pkg::DIV_DVD_W;
    localparam int DVS_W = mdag_pkg::DIV_DVS_W;
    localparam int QUO_W = mdag_pkg::DIV_QUO_W;
    localparam int SH_W  = DVS_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic             ge;

    assign ge = SH_W'(rem_reg) >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            ovf_next  = SH_W'(dividend) >= (SH_W'(divisor) << QUO_W);
            rem_next  = dividend;
            dsh_next  = SH_W'(divisor) << (QUO_W - 1);
            cnt_next  = CNT_W'(QUO_W - 1);
            q_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg[DVD_W-1:0];
            end
            q_next   = {q_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

[src/mdag_regs.sv]
// APB configuration registers: coefficients, target level, gate threshold, AGC enable.
// Depends on mdag_pkg for the register struct, indexes and reset values.
module mdag_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mdag_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mdag_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mdag_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output mdag_pkg::cfg_t                    cfg
);

    localparam int DW = mdag_pkg::APB_DATA_W;

    mdag_pkg::cfg_t     cfg_reg, cfg_next;
    mdag_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = mdag_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                mdag_pkg::REG_HIGHPASS:    cfg_next.highpass_coef    = pwdata[23:0];
                mdag_pkg::REG_ATTACK:      cfg_next.attack_coef      = pwdata[23:0];
                mdag_pkg::REG_RELEASE:     cfg_next.release_coef     = pwdata[23:0];
                mdag_pkg::REG_GATE_SMOOTH: cfg_next.gate_smooth_coef = pwdata[23:0];
                mdag_pkg::REG_GAIN_SLEW:   cfg_next.gain_slew_coef   = pwdata[23:0];
                mdag_pkg::REG_TARGET:      cfg_next.target_level     = pwdata[14:0];
                mdag_pkg::REG_GATE_THR:    cfg_next.gate_threshold   = pwdata[14:0];
                mdag_pkg::REG_AGC_EN:      cfg_next.agc_enable       = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mdag_pkg::REG_HIGHPASS:    prdata = DW'(cfg_reg.highpass_coef);
            mdag_pkg::REG_ATTACK:      prdata = DW'(cfg_reg.attack_coef);
            mdag_pkg::REG_RELEASE:     prdata = DW'(cfg_reg.release_coef);
            mdag_pkg::REG_GATE_SMOOTH: prdata = DW'(cfg_reg.gate_smooth_coef);
            mdag_pkg::REG_GAIN_SLEW:   prdata = DW'(cfg_reg.gain_slew_coef);
            mdag_pkg::REG_TARGET:      prdata = DW'(cfg_reg.target_level);
            mdag_pkg::REG_GATE_THR:    prdata = DW'(cfg_reg.gate_threshold);
            mdag_pkg::REG_AGC_EN:      prdata = DW'(cfg_reg.agc_enable);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mdag_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/mic_dc_block_agc_gate.sv]
// Top level: DC blocker, level envelope, AGC and noise gate around one shared
// multiplier and one shared divider. Depends on mdag_pkg, mdag_if, mdag_mul,
// mdag_div and mdag_regs.
//
//   port      dir  handshake      payload
//   din       in   valid/ready    in_sample  (16 bit signed)
//   dout      out  valid/ready    out_sample (16 bit signed)
//   apb       in   psel/penable   8 registers at 4*i, 32 bit data, pready tied high
//
// AGC off with the gate open is the shortest path through the states; the longest
// runs both the gain division and the gate division, each a pass of 17 quotient
// bits through the shared divider, and every multiply goes through its product register.
// din.ready is high only in the idle state; a result waits in the output
// register while the next item is taken. Reset clears all filter state to zero
// and the gain to unity; there is no clearing pass.
module mic_dc_block_agc_gate #(
    parameter int COEF_BITS = mdag_pkg::COEF_BITS_DEF,
    parameter int GAIN_MAX  = mdag_pkg::GAIN_MAX_DEF,
    parameter int GAIN_MIN  = mdag_pkg::GAIN_MIN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mdag_in_if.sink                         din,
    mdag_out_if.source                      dout,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mdag_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mdag_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mdag_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int SW    = mdag_pkg::SAMPLE_W;
    localparam int EW    = mdag_pkg::ENV_W;
    localparam int GW    = mdag_pkg::GAIN_W;
    localparam int FW    = mdag_pkg::GATE_F_W;
    localparam int BW    = mdag_pkg::HP_MAG_W;
    localparam int AW    = COEF_BITS;
    localparam int MW    = AW + BW;
    localparam int QW    = mdag_pkg::DIV_QUO_W;
    localparam int DDW   = mdag_pkg::DIV_DVD_W;
    localparam int DSW   = mdag_pkg::DIV_DVS_W;
    localparam int OPW   = EW + GW;

    localparam logic [MW-1:0] HALF      = MW'(1) << (COEF_BITS - 1);
    localparam logic [31:0]   COEF_MAX  = 32'((64'd1 << COEF_BITS) - 64'd1);
    localparam logic [GW-1:0] GMAX      = GW'(GAIN_MAX);
    localparam logic [GW-1:0] GMIN      = GW'(GAIN_MIN);
    localparam logic [QW-1:0] QMAX      = QW'(GAIN_MAX);
    localparam logic [QW-1:0] QMIN      = QW'(GAIN_MIN);
    localparam logic [GW-1:0] GONE      = GW'(mdag_pkg::GAIN_ONE);
    localparam logic [FW-1:0] FLOOR_F   = FW'(mdag_pkg::GATE_FLOOR);
    localparam logic [FW-1:0] ONE_F     = FW'(mdag_pkg::GATE_ONE);
    localparam logic [AW-1:0] SPAN_A    = AW'(mdag_pkg::GATE_SPAN);
    localparam logic [EW-1:0] QUIET_ENV = EW'(mdag_pkg::ENV_QUIET);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_HP_SUM   = 22'h000002,
        S_HP_MUL   = 22'h000004,
        S_HP_OUT   = 22'h000008,
        S_ENV_DIFF = 22'h000010,
        S_ENV_MUL  = 22'h000020,
        S_ENV_UPD  = 22'h000040,
        S_GT_DIFF  = 22'h000080,
        S_GT_MUL   = 22'h000100,
        S_GT_UPD   = 22'h000200,
        S_AGC_SEL  = 22'h000400,
        S_AGC_DIV  = 22'h000800,
        S_AGC_DIFF = 22'h001000,
        S_AGC_MUL  = 22'h002000,
        S_AGC_UPD  = 22'h004000,
        S_GF_MUL   = 22'h008000,
        S_GF_DIV   = 22'h010000,
        S_GF_WAIT  = 22'h020000,
        S_GFA_MUL  = 22'h040000,
        S_GFA_UPD  = 22'h080000,
        S_OUT_MUL  = 22'h100000,
        S_OUT_RND  = 22'h200000
    } state_t;

    mdag_pkg::cfg_t          cfg;
    mdag_pkg::div_status_t   div_st;

    state_t                  state_reg, state_next;
    logic signed [SW-1:0]    x_reg, x_next;
    logic signed [SW-1:0]    hp_in_reg, hp_in_next;
    logic [EW-1:0]           hp_out_reg, hp_out_next;
    logic [EW-1:0]           level_env_reg, level_env_next;
    logic [EW-1:0]           gate_env_reg, gate_env_next;
    logic [GW-1:0]           gain_reg, gain_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    out_sample_reg, out_sample_next;

    logic [BW-1:0]           op_reg, op_next;
    logic                    neg_reg, neg_next;
    logic                    sub_reg, sub_next;
    logic                    yneg_reg, yneg_next;
    logic [EW-1:0]           mag_reg, mag_next;
    logic [GW-1:0]           want_reg, want_next;
    logic [GW-1:0]           g_reg, g_next;
    logic [FW-1:0]           f_reg, f_next;

    logic                    mul_en;
    logic [AW-1:0]           mul_a;
    logic [BW-1:0]           mul_b;
    logic [MW-1:0]           mul_p;

    logic                    div_start;
    logic [DDW-1:0]          div_dvd;
    logic [DSW-1:0]          div_dvs;
    logic [QW-1:0]           div_q;

    logic [AW-1:0]           c_hp, c_att, c_rel, c_gate, c_slew;
    logic [SW:0]             hp_dx;
    logic [BW-1:0]           hp_sum;
    logic [BW-1:0]           hp_smag;
    logic [MW-1:0]           hp_acc;
    logic [BW-1:0]           hp_pm;
    logic [EW-1:0]           y_val, y_mag;
    logic [EW-2:0]           gate_th;
    logic                    gate_on;
    logic [FW:0]             f_sum;
    logic [32:0]             ga_acc;
    logic [OPW-1:0]          out_prod;
    logic [QW+2:0]           out_q;
    logic [19:0]             out_r;
    logic                    out_inc;
    logic [QW+3:0]           out_qr;
    logic signed [SW-1:0]    out_val;

    function automatic logic [AW-1:0] coef_sat(input logic [mdag_pkg::COEF_REG_W-1:0] c);
        logic [31:0] ext;
        ext = 32'(c);
        if (ext > COEF_MAX)
        begin
            ext = COEF_MAX;
        end
        return ext[AW-1:0];
    endfunction

    function automatic logic [EW-1:0] smooth_fin(input logic [EW-1:0] m,
                                                 input logic [MW-1:0] p,
                                                 input logic          sub);
        logic [MW-1:0] base;
        logic [MW-1:0] acc;
        base = MW'(m) << COEF_BITS;
        acc  = sub ? (base - p + HALF) : (base + p + HALF);
        return acc[COEF_BITS+EW-1:COEF_BITS];
    endfunction

    mdag_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mdag_mul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mdag_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .status   (div_st)
    );

    assign c_hp   = coef_sat(cfg.highpass_coef);
    assign c_att  = coef_sat(cfg.attack_coef);
    assign c_rel  = coef_sat(cfg.release_coef);
    assign c_gate = coef_sat(cfg.gate_smooth_coef);
    assign c_slew = coef_sat(cfg.gain_slew_coef);

    assign hp_dx   = {x_reg[SW-1], x_reg} - {hp_in_reg[SW-1], hp_in_reg};
    assign hp_sum  = {{(BW-EW){hp_out_reg[EW-1]}}, hp_out_reg} + {hp_dx[SW], hp_dx, 8'b0};
    assign hp_smag = hp_sum[BW-1] ? (BW'(0) - hp_sum) : hp_sum;
    assign hp_acc  = mul_p + HALF;
    assign hp_pm   = hp_acc[MW-1:COEF_BITS];

    always_comb
    begin
        if (!neg_reg)
        begin
            if (hp_pm > BW'(mdag_pkg::Y_POS_MAX))
            begin
                y_val = mdag_pkg::Y_POS_MAX;
            end
            else
            begin
                y_val = hp_pm[EW-1:0];
            end
            y_mag = y_val;
        end
        else
        begin
            if (hp_pm > BW'(mdag_pkg::Y_NEG_MAG))
            begin
                y_mag = mdag_pkg::Y_NEG_MAG;
            end
            else
            begin
                y_mag = hp_pm[EW-1:0];
            end
            y_val = EW'(0) - y_mag;
        end
    end

    assign gate_th = {cfg.gate_threshold, 8'b0};
    assign gate_on = gate_env_reg < EW'(gate_th);
    assign f_sum   = (FW+1)'(FLOOR_F) + (FW+1)'(div_q);
    assign ga_acc  = mul_p[32:0] + 33'd32768;

    assign out_prod = mul_p[OPW-1:0];
    assign out_q    = out_prod[OPW-1:20];
    assign out_r    = out_prod[19:0];
    assign out_inc  = (out_r > 20'h80000) || ((out_r == 20'h80000) && out_q[0]);
    assign out_qr   = {1'b0, out_q} + (QW+4)'(out_inc);

    always_comb
    begin
        if (yneg_reg)
        begin
            if (out_qr > (QW+4)'(32768))
            begin
                out_val = 16'sh8000;
            end
            else
            begin
                out_val = SW'(0) - out_qr[SW-1:0];
            end
        end
        else
        begin
            if (out_qr > (QW+4)'(32767))
            begin
                out_val = 16'sh7FFF;
            end
            else
            begin
                out_val = out_qr[SW-1:0];
            end
        end
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = c_hp;
        mul_b  = op_reg;
        unique case (state_reg)
            S_HP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = c_hp;
            end
            S_ENV_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = sub_reg ? c_att : c_rel;
            end
            S_GT_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = c_gate;
            end
            S_AGC_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = c_slew;
            end
            S_GF_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = SPAN_A;
                mul_b  = BW'(gate_env_reg);
            end
            S_GFA_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = AW'(g_reg);
                mul_b  = BW'(f_reg);
            end
            S_OUT_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = AW'(g_reg);
                mul_b  = BW'(mag_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign din.ready       = (state_reg == S_IDLE);
    assign dout.valid      = out_valid_reg;
    assign dout.out_sample = out_sample_reg;

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        hp_in_next      = hp_in_reg;
        hp_out_next     = hp_out_reg;
        level_env_next  = level_env_reg;
        gate_env_next   = gate_env_reg;
        gain_next       = gain_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        op_next         = op_reg;
        neg_next        = neg_reg;
        sub_next        = sub_reg;
        yneg_next       = yneg_reg;
        mag_next        = mag_reg;
        want_next       = want_reg;
        g_next          = g_reg;
        f_next          = f_reg;
        div_start       = 1'b0;
        div_dvd         = DDW'({cfg.target_level, 20'b0}) + DDW'(level_env_reg >> 1);
        div_dvs         = DSW'(level_env_reg);

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    x_next     = din.in_sample;
                    state_next = S_HP_SUM;
                end
            end
            S_HP_SUM:
            begin
                neg_next   = hp_sum[BW-1];
                op_next    = hp_smag;
                state_next = S_HP_MUL;
            end
            S_HP_MUL:
            begin
                state_next = S_HP_OUT;
            end
            S_HP_OUT:
            begin
                hp_in_next  = x_reg;
                hp_out_next = y_val;
                mag_next    = y_mag;
                yneg_next   = neg_reg && (hp_pm != '0);
                state_next  = S_ENV_DIFF;
            end
            S_ENV_DIFF:
            begin
                sub_next   = level_env_reg < mag_reg;
                op_next    = (level_env_reg < mag_reg) ? BW'(mag_reg - level_env_reg)
                                                       : BW'(level_env_reg - mag_reg);
                state_next = S_ENV_MUL;
            end
            S_ENV_MUL:
            begin
                state_next = S_ENV_UPD;
            end
            S_ENV_UPD:
            begin
                level_env_next = smooth_fin(mag_reg, mul_p, sub_reg);
                state_next     = S_GT_DIFF;
            end
            S_GT_DIFF:
            begin
                sub_next   = gate_env_reg < mag_reg;
                op_next    = (gate_env_reg < mag_reg) ? BW'(mag_reg - gate_env_reg)
                                                      : BW'(gate_env_reg - mag_reg);
                state_next = S_GT_MUL;
            end
            S_GT_MUL:
            begin
                state_next = S_GT_UPD;
            end
            S_GT_UPD:
            begin
                gate_env_next = smooth_fin(mag_reg, mul_p, sub_reg);
                state_next    = S_AGC_SEL;
            end
            S_AGC_SEL:
            begin
                if (!cfg.agc_enable)
                begin
                    g_next     = GONE;
                    state_next = gate_on ? S_GF_MUL : S_OUT_MUL;
                end
                else if (level_env_reg > QUIET_ENV)
                begin
                    div_start  = 1'b1;
                    state_next = S_AGC_DIV;
                end
                else
                begin
                    want_next  = GMAX;
                    state_next = S_AGC_DIFF;
                end
            end
            S_AGC_DIV:
            begin
                if (div_st.done)
                begin
                    if (div_st.ovf || (div_q > QMAX))
                    begin
                        want_next = GMAX;
                    end
                    else if (div_q < QMIN)
                    begin
                        want_next = GMIN;
                    end
                    else
                    begin
                        want_next = div_q[GW-1:0];
                    end
                    state_next = S_AGC_DIFF;
                end
            end
            S_AGC_DIFF:
            begin
                sub_next   = gain_reg < want_reg;
                op_next    = (gain_reg < want_reg) ? BW'(want_reg - gain_reg)
                                                   : BW'(gain_reg - want_reg);
                state_next = S_AGC_MUL;
            end
            S_AGC_MUL:
            begin
                state_next = S_AGC_UPD;
            end
            S_AGC_UPD:
            begin
                gain_next  = GW'(smooth_fin(EW'(want_reg), mul_p, sub_reg));
                g_next     = GW'(smooth_fin(EW'(want_reg), mul_p, sub_reg));
                state_next = gate_on ? S_GF_MUL : S_OUT_MUL;
            end
            S_GF_MUL:
            begin
                state_next = S_GF_DIV;
            end
            S_GF_DIV:
            begin
                div_start  = 1'b1;
                div_dvd    = mul_p[DDW-1:0] + DDW'(gate_th >> 1);
                div_dvs    = DSW'(gate_th);
                state_next = S_GF_WAIT;
            end
            S_GF_WAIT:
            begin
                if (div_st.done)
                begin
                    if (f_sum > (FW+1)'(ONE_F))
                    begin
                        f_next = ONE_F;
                    end
                    else
                    begin
                        f_next = f_sum[FW-1:0];
                    end
                    state_next = S_GFA_MUL;
                end
            end
            S_GFA_MUL:
            begin
                state_next = S_GFA_UPD;
            end
            S_GFA_UPD:
            begin
                g_next     = ga_acc[31:16];
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                state_next = S_OUT_RND;
            end
            S_OUT_RND:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_sample_next = out_val;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hp_in_reg     <= '0;
            hp_out_reg    <= '0;
            level_env_reg <= '0;
            gate_env_reg  <= '0;
            gain_reg      <= GONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hp_in_reg     <= hp_in_next;
            hp_out_reg    <= hp_out_next;
            level_env_reg <= level_env_next;
            gate_env_reg  <= gate_env_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        out_sample_reg <= out_sample_next;
        op_reg         <= op_next;
        neg_reg        <= neg_next;
        sub_reg        <= sub_next;
        yneg_reg       <= yneg_next;
        mag_reg        <= mag_next;
        want_reg       <= want_next;
        g_reg          <= g_next;
        f_reg          <= f_next;
    end

endmodule
